/* design/pitch_pd_pkg.sv */
package pitch_pd_pkg;

  // data widths
  localparam int unsigned DataW   = 16;
  localparam int unsigned CmdW    = 17;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // register index codes (byte address / 4)
  localparam logic [2:0] REG_PITCH_GAIN       = 3'd0;
  localparam logic [2:0] REG_PITCH_RATE_GAIN  = 3'd1;
  localparam logic [2:0] REG_RUDDER_MIX_GAIN  = 3'd2;
  localparam logic [2:0] REG_ROLL_MIX_GAIN    = 3'd3;
  localparam logic [2:0] REG_RETURN_KICK      = 3'd4;
  localparam logic [2:0] REG_INVERTED_NEUTRAL = 3'd5;
  localparam logic [2:0] REG_STABILIZE_ENABLE = 3'd6;
  localparam logic [2:0] REG_RUDDER_MIX_MODE  = 3'd7;

  // rudder mix mode codes
  localparam logic [1:0] MIX_OFF      = 2'd0;
  localparam logic [1:0] MIX_NORMAL   = 2'd1;
  localparam logic [1:0] MIX_REVERSED = 2'd2;

  // control flags that travel down the pipeline with each request
  typedef struct packed {
    logic hover;
    logic rud_en;
    logic roll_en;
    logic pd_en;
  } ctl_t;

endpackage

/* design/pitch_attitude_pd_control.sv */
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_ready  | mode flags, mat_*, gyro_*, altitude_adjust,
//          |                      | rudder_deflection
// out      | out_valid / out_ready| elevator_command, pitch_rate, pitch_rate_valid,
//          |                      | altitude_adjust_out
// cfg      | APB psel/penable     | eight control registers at 4*i, pready tied high
//
// five register stages: input prep, first multiplies, rate and mix multiplies,
// rate-gain multiply and mix sum, output register; the multiplier chain sets that
// stage count. one request enters per cycle unless the output is stalled.
// rst (synchronous) clears all stage valid bits and the control registers.
// a stalled output holds; each stage loads only when it is empty or the stage after
// it loads, so bubbles collapse and nothing is dropped or repeated.
module pitch_attitude_pd_control (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 hover_mode,
  input  logic                                 inverted_active,
  input  logic                                 feedback_on,
  input  logic                                 radio_link,
  input  logic                                 nav_steering,
  input  logic signed [pitch_pd_pkg::DataW-1:0] mat_six,
  input  logic signed [pitch_pd_pkg::DataW-1:0] mat_seven,
  input  logic signed [pitch_pd_pkg::DataW-1:0] mat_eight,
  input  logic signed [pitch_pd_pkg::DataW-1:0] gyro_roll,
  input  logic signed [pitch_pd_pkg::DataW-1:0] gyro_yaw,
  input  logic signed [pitch_pd_pkg::DataW-1:0] altitude_adjust,
  input  logic signed [pitch_pd_pkg::DataW-1:0] rudder_deflection,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pitch_pd_pkg::CmdW-1:0]  elevator_command,
  output logic signed [pitch_pd_pkg::DataW-1:0] pitch_rate,
  output logic                                 pitch_rate_valid,
  output logic signed [pitch_pd_pkg::DataW-1:0] altitude_adjust_out,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pitch_pd_pkg::ApbAddrW-1:0]     paddr,
  input  logic [pitch_pd_pkg::ApbDataW-1:0]     pwdata,
  output logic [pitch_pd_pkg::ApbDataW-1:0]     prdata,
  output logic                                 pready
);
  import pitch_pd_pkg::*;

  // control registers
  logic        [DataW-1:0] pitch_gain;
  logic        [DataW-1:0] pitch_rate_gain;
  logic        [DataW-1:0] rudder_mix_gain;
  logic        [DataW-1:0] roll_mix_gain;
  logic signed [DataW-1:0] return_kick;
  logic signed [DataW-1:0] inverted_neutral;
  logic                    stabilize_enable;
  logic        [1:0]       rudder_mix_mode;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_gain       <= '0;
      pitch_rate_gain  <= '0;
      rudder_mix_gain  <= '0;
      roll_mix_gain    <= '0;
      return_kick      <= '0;
      inverted_neutral <= '0;
      stabilize_enable <= 1'b0;
      rudder_mix_mode  <= MIX_OFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PITCH_GAIN:       pitch_gain       <= pwdata[DataW-1:0];
        REG_PITCH_RATE_GAIN:  pitch_rate_gain  <= pwdata[DataW-1:0];
        REG_RUDDER_MIX_GAIN:  rudder_mix_gain  <= pwdata[DataW-1:0];
        REG_ROLL_MIX_GAIN:    roll_mix_gain    <= pwdata[DataW-1:0];
        REG_RETURN_KICK:      return_kick      <= pwdata[DataW-1:0];
        REG_INVERTED_NEUTRAL: inverted_neutral <= pwdata[DataW-1:0];
        REG_STABILIZE_ENABLE: stabilize_enable <= pwdata[0];
        REG_RUDDER_MIX_MODE:  rudder_mix_mode  <= pwdata[1:0];
        default:              ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_index)
      REG_PITCH_GAIN:       prdata = {16'd0, pitch_gain};
      REG_PITCH_RATE_GAIN:  prdata = {16'd0, pitch_rate_gain};
      REG_RUDDER_MIX_GAIN:  prdata = {16'd0, rudder_mix_gain};
      REG_ROLL_MIX_GAIN:    prdata = {16'd0, roll_mix_gain};
      REG_RETURN_KICK:      prdata = {16'd0, return_kick};
      REG_INVERTED_NEUTRAL: prdata = {16'd0, inverted_neutral};
      REG_STABILIZE_ENABLE: prdata = {31'd0, stabilize_enable};
      REG_RUDDER_MIX_MODE:  prdata = {30'd0, rudder_mix_mode};
      default:              prdata = '0;
    endcase
  end

  // stage valid bits and load enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // stage 1: inversion, kick, pitch error, rudder sign
  logic                    inv;
  logic signed [DataW-1:0] m6_n, m7_n, m8_n, alt_n, kick, err_n, dev_n;
  ctl_t                    ctl_n;

  always_comb begin
    inv   = inverted_active && !hover_mode;
    m6_n  = inv ? -mat_six : mat_six;
    m7_n  = inv ? -mat_seven : mat_seven;
    m8_n  = inv ? -mat_eight : mat_eight;
    alt_n = inv ? (-altitude_adjust - inverted_neutral) : altitude_adjust;
    kick  = (!radio_link && nav_steering) ? return_kick : '0;
    err_n = m7_n - kick + alt_n;
    dev_n = (rudder_mix_mode == MIX_REVERSED) ? -rudder_deflection : rudder_deflection;
    ctl_n.hover   = hover_mode;
    ctl_n.rud_en  = feedback_on &&
                    (rudder_mix_mode == MIX_NORMAL || rudder_mix_mode == MIX_REVERSED);
    ctl_n.roll_en = feedback_on;
    ctl_n.pd_en   = stabilize_enable && feedback_on;
  end

  ctl_t                    s1_ctl;
  logic signed [DataW-1:0] s1_m6, s1_m6raw, s1_m8, s1_g0, s1_g2, s1_err, s1_dev, s1_alt;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ctl   <= ctl_n;
      s1_m6    <= m6_n;
      s1_m6raw <= mat_six;
      s1_m8    <= m8_n;
      s1_g0    <= gyro_roll;
      s1_g2    <= gyro_yaw;
      s1_err   <= err_n;
      s1_dev   <= dev_n;
      s1_alt   <= alt_n;
    end
  end

  // stage 2: first rank of multiplies
  logic signed [ProdW:0]   p_rud, p_roll, p_err;
  logic signed [ProdW-1:0] p_a, p_b;

  always_comb begin
    p_rud  = s1_m6 * $signed({1'b0, rudder_mix_gain});
    p_roll = s1_m6 * $signed({1'b0, roll_mix_gain});
    p_err  = s1_err * $signed({1'b0, pitch_gain});
    p_a    = s1_m8 * s1_g0;
    p_b    = s1_m6 * s1_g2;
  end

  ctl_t                    s2_ctl;
  logic signed [DataW-1:0] s2_rud_hi, s2_roll_hi, s2_m6raw, s2_dev, s2_alt;
  logic signed [ProdW-1:0] s2_pa, s2_pb, s2_pe;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ctl     <= s1_ctl;
      s2_rud_hi  <= p_rud[30:15];
      s2_roll_hi <= p_roll[30:15];
      s2_pe      <= p_err[ProdW-1:0];
      s2_pa      <= p_a;
      s2_pb      <= p_b;
      s2_m6raw   <= s1_m6raw;
      s2_dev     <= s1_dev;
      s2_alt     <= s1_alt;
    end
  end

  // stage 3: body pitch rate and second mix multiplies
  logic signed [ProdW-1:0] rate_diff, q_rud, q_roll;

  always_comb begin
    rate_diff = s2_pa - s2_pb;
    q_rud     = s2_rud_hi * s2_dev;
    q_roll    = s2_roll_hi * s2_m6raw;
  end

  ctl_t                    s3_ctl;
  logic signed [DataW-1:0] s3_rate, s3_alt;
  logic signed [ProdW-1:0] s3_qrud, s3_qroll, s3_pe;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ctl   <= s2_ctl;
      s3_rate  <= rate_diff[30:15];
      s3_qrud  <= q_rud;
      s3_qroll <= q_roll;
      s3_pe    <= s2_pe;
      s3_alt   <= s2_alt;
    end
  end

  // stage 4: rate gain multiply and mix sum
  logic signed [ProdW:0]   p_rate;
  logic signed [DataW-1:0] mix_rud, mix_roll, mix_sum;

  always_comb begin
    p_rate   = s3_rate * $signed({1'b0, pitch_rate_gain});
    mix_rud  = s3_ctl.rud_en ? s3_qrud[28:13] : '0;
    mix_roll = s3_ctl.roll_en ? {{3{s3_qroll[31]}}, s3_qroll[31:19]} : '0;
    mix_sum  = mix_rud + mix_roll;
  end

  ctl_t                    s4_ctl;
  logic signed [DataW-1:0] s4_rate, s4_alt, s4_mix;
  logic signed [ProdW-1:0] s4_prg, s4_pe;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_ctl  <= s3_ctl;
      s4_rate <= s3_rate;
      s4_alt  <= s3_alt;
      s4_mix  <= mix_sum;
      s4_prg  <= p_rate[ProdW-1:0];
      s4_pe   <= s3_pe;
    end
  end

  // stage 5: pd high word, command sum, hover override
  logic signed [ProdW-1:0] pd_acc;
  logic signed [DataW-1:0] pd_term;
  logic signed [CmdW-1:0]  cmd_n;

  always_comb begin
    pd_acc  = s4_pe + s4_prg;
    pd_term = s4_ctl.pd_en ? pd_acc[31:16] : '0;
    cmd_n   = CmdW'(pd_term) + CmdW'(s4_mix);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      elevator_command    <= s4_ctl.hover ? '0 : cmd_n;
      pitch_rate          <= s4_ctl.hover ? '0 : s4_rate;
      pitch_rate_valid    <= !s4_ctl.hover;
      altitude_adjust_out <= s4_alt;
    end
  end

endmodule

/* design/pitch_pd_checker.sv */
module pitch_pd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [pitch_pd_pkg::CmdW-1:0]  elevator_command,
  input logic signed [pitch_pd_pkg::DataW-1:0] pitch_rate,
  input logic                                 pitch_rate_valid,
  input logic                                 pready
);
  import pitch_pd_pkg::*;

  // a reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid seen right after reset");

  // a stalled result holds still
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(elevator_command) &&
                                $stable(pitch_rate) && $stable(pitch_rate_valid))
    else $error("stalled result changed");

  // hover results carry a zero command and zero rate
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !pitch_rate_valid |-> elevator_command == '0 && pitch_rate == '0)
    else $error("hover result not zero");

  // an empty output register always leaves room for a new request
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // the configuration port never waits
  assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind pitch_attitude_pd_control pitch_pd_checker u_pitch_pd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .elevator_command (elevator_command),
  .pitch_rate       (pitch_rate),
  .pitch_rate_valid (pitch_rate_valid),
  .pready           (pready)
);
